// ===== hdl/cdq_pkg.sv =====
// Shared constants and types for the circular deque ring core.
`default_nettype none
package cdq_pkg;

  // Operation codes carried in the input tuser field
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_INS_FRONT = 2'd0;
  localparam mode_t MODE_INS_REAR  = 2'd1;
  localparam mode_t MODE_DEL_FRONT = 2'd2;
  localparam mode_t MODE_DEL_REAR  = 2'd3;

  // Configuration bus
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  // Register index of the capacity register
  localparam logic REG_CAPACITY = 1'b0;

endpackage
`default_nettype wire

// ===== hdl/circular_deque_ring_core.sv =====
// Top level of the circular deque ring core: pointer control around the slot RAM.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+--------------------------------------
//  s_axis    | in  | tvalid / tready         | tuser: mode; tdata: item_value
//  m_axis    | out | tvalid / tready         | tuser: accepted, is_empty, is_full;
//            |     |                         | tdata: front_value, rear_value
//  apb       | in  | psel, penable, pready=1 | capacity_in_use at byte address 0
//
// Each item goes through accept (pointer update and slot write), then a RAM read of
// both ends through the registered read ports, then result hold through any output stall.
// One item is in flight at a time; s_axis_tready is high only when idle.
// A stalled result holds in place until m_axis_tready is seen.
// Reset empties the deque and sets the capacity to STORE_DEPTH; no clearing pass.
// A capacity write empties the deque; the user must issue it only while idle, as the block does not enforce this.
`default_nettype none
module circular_deque_ring_core
  import cdq_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned IN_DW  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input items
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_DW-1:0]  s_axis_tdata,   // [VW-1:0] item_value, rest zero
  input  wire logic [1:0]        s_axis_tuser,   // [1:0] mode
  // result items
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_DW-1:0] m_axis_tdata,   // front_value, rear_value, zero fill
  output logic      [2:0]        m_axis_tuser,   // accepted, is_empty, is_full
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] front_q, front_d;
  logic [PW-1:0] rear_q, rear_d;
  logic [CW-1:0] count_q, count_d;
  logic          ok_q, ok_d;
  logic          empty_q, empty_d;
  logic          full_q, full_d;

  logic [CW-1:0]          cap_eff;
  logic                   cfg_clear;
  logic                   s_fire, m_fire;
  logic                   cur_full, cur_empty;
  logic                   ram_we;
  logic [PW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_rd_front, ram_rd_rear;
  logic [VALUE_WIDTH-1:0] front_val, rear_val;
  mode_t                  mode;

  // Ring pointer steps within the capacity in use
  function automatic logic [PW-1:0] step_down(input logic [PW-1:0] p,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] pw;
    pw = CW'(p);
    if (pw == '0 || pw >= cap) begin
      step_down = PW'(cap - 1'b1);
    end else begin
      step_down = PW'(pw - 1'b1);
    end
  endfunction

  function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(p) + 1'b1;
    if (nxt >= cap) begin
      step_up = '0;
    end else begin
      step_up = PW'(nxt);
    end
  endfunction

  cdq_cfg #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_eff_o (cap_eff),
    .clear_o   (cfg_clear)
  );

  cdq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (s_axis_tdata[VALUE_WIDTH-1:0]),
    .re_i      (state_q == ST_READ),
    .raddr_a_i (front_q),
    .raddr_b_i (rear_q),
    .rdata_a_o (ram_rd_front),
    .rdata_b_o (ram_rd_rear)
  );

  assign mode          = s_axis_tuser;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign cur_full      = (count_q >= cap_eff);
  assign cur_empty     = (count_q == '0);

  // Operation decode: pointer moves, slot write and count update
  always_comb begin
    front_d   = front_q;
    rear_d    = rear_q;
    count_d   = count_q;
    ok_d      = ok_q;
    empty_d   = empty_q;
    full_d    = full_q;
    ram_we    = 1'b0;
    ram_waddr = front_q;
    if (cfg_clear) begin
      front_d = '0;
      rear_d  = '0;
      count_d = '0;
    end else if (s_fire) begin
      ok_d = 1'b0;
      unique case (mode)
        MODE_INS_FRONT: begin
          if (!cur_full) begin
            front_d   = step_down(front_q, cap_eff);
            rear_d    = cur_empty ? front_d : rear_q;
            ram_we    = 1'b1;
            ram_waddr = front_d;
            count_d   = count_q + 1'b1;
            ok_d      = 1'b1;
          end
        end
        MODE_INS_REAR: begin
          if (!cur_full) begin
            rear_d    = step_up(rear_q, cap_eff);
            front_d   = cur_empty ? rear_d : front_q;
            ram_we    = 1'b1;
            ram_waddr = rear_d;
            count_d   = count_q + 1'b1;
            ok_d      = 1'b1;
          end
        end
        MODE_DEL_FRONT: begin
          if (!cur_empty) begin
            front_d = step_up(front_q, cap_eff);
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        MODE_DEL_REAR: begin
          if (!cur_empty) begin
            rear_d  = step_down(rear_q, cap_eff);
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        default: ;
      endcase
      empty_d = (count_d == '0);
      full_d  = (count_d >= cap_eff);
    end
  end

  // Sequencer: accept, read both ends, hold result
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_fire) state_d = ST_READ;
      ST_READ: state_d = ST_OUT;
      ST_OUT:  if (m_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
    end
  end

  // Result flags are payload
  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    empty_q <= empty_d;
    full_q  <= full_d;
  end

  // Result payload: empty deque reports all ones at both ends
  assign front_val = empty_q ? '1 : ram_rd_front;
  assign rear_val  = empty_q ? '1 : ram_rd_rear;
  assign m_axis_tdata = OUT_DW'({rear_val, front_val});
  assign m_axis_tuser = {full_q, empty_q, ok_q};

  // Checks
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= cap_eff) || $past(cfg_clear))
    else $error("item count above capacity");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_READ))
    else $error("accepted item did not start its read");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && empty_q) |-> (front_val == '1 && rear_val == '1))
    else $error("empty result carries slot data");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== hdl/cdq_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cdq_cfg.sv =====
// APB capacity register with effective-capacity clamp and clear strobe.
`default_nettype none
module cdq_cfg
  import cdq_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16,
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [CW-1:0]     cap_eff_o,
  output logic                   clear_o
);

  logic [CW-1:0] cap_q, cap_d;
  logic          wr_cap;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign clear_o = wr_cap;

  always_comb begin
    cap_d = cap_q;
    if (wr_cap) begin
      cap_d = pwdata[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(STORE_DEPTH);
    end else begin
      cap_q <= cap_d;
    end
  end

  // Read back the raw register value
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(cap_q);
    end
  end

  // Zero acts as one slot, anything above the store depth as the full store
  always_comb begin
    if (cap_q == '0) begin
      cap_eff_o = CW'(1);
    end else if (cap_q > CW'(STORE_DEPTH)) begin
      cap_eff_o = CW'(STORE_DEPTH);
    end else begin
      cap_eff_o = cap_q;
    end
  end

endmodule
`default_nettype wire

// ===== tb/circular_deque_ring_core_tb.sv =====
// Self-checking testbench for circular_deque_ring_core: stream traffic with APB capacity writes.
`default_nettype none
module circular_deque_ring_core_tb;
  import cdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  // one result item as seen on m_axis
  typedef struct packed {
    logic        accepted;
    logic [31:0] front_value;
    logic [31:0] rear_value;
    logic        is_empty;
    logic        is_full;
  } deque_report_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  circular_deque_ring_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] item_value
    .s_axis_tuser  (s_axis_tuser),   // [1:0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] front_value, [63:32] rear_value
    .m_axis_tuser  (m_axis_tuser),   // [0] accepted, [1] is_empty, [2] is_full
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow deque state
  logic [31:0]   shadow_slots [DEPTH];
  int            head_pos;
  int            tail_pos;
  int            fill_count;
  logic [4:0]    cap_reg;
  deque_report_t pending_reports[$];

  // Run bookkeeping
  int  fail_count;
  int  cycle_count;
  int  items_sent;
  int  reports_seen;
  int  refused_ops;
  int  full_reports;
  int  cap_writes;
  bit  src_idle_on;
  bit  snk_idle_on;
  int  stall_left;
  int  flow_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Capacity register as the ring sees it
  function automatic int ring_size(logic [4:0] r);
    if (r == 5'd0) return 1;
    if (r > 5'(DEPTH)) return DEPTH;
    return int'(r);
  endfunction

  function automatic int ring_prev(int p, int cap);
    return (p == 0 || p >= cap) ? cap - 1 : p - 1;
  endfunction

  function automatic int ring_next(int p, int cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  // Apply one operation to the shadow deque and return the report it produces
  function automatic deque_report_t apply_deque_op(mode_t m, logic [31:0] v);
    int            cap;
    logic          was_full;
    logic          was_empty;
    deque_report_t r;
    cap       = ring_size(cap_reg);
    was_full  = fill_count >= cap;
    was_empty = fill_count == 0;
    r.accepted = 1'b0;
    case (m)
      MODE_INS_FRONT: begin
        if (!was_full) begin
          head_pos = ring_prev(head_pos, cap);
          if (was_empty) tail_pos = head_pos;
          shadow_slots[head_pos] = v;
          fill_count++;
          r.accepted = 1'b1;
        end
      end
      MODE_INS_REAR: begin
        if (!was_full) begin
          tail_pos = ring_next(tail_pos, cap);
          if (was_empty) head_pos = tail_pos;
          shadow_slots[tail_pos] = v;
          fill_count++;
          r.accepted = 1'b1;
        end
      end
      MODE_DEL_FRONT: begin
        if (!was_empty) begin
          head_pos = ring_next(head_pos, cap);
          fill_count--;
          r.accepted = 1'b1;
        end
      end
      default: begin
        if (!was_empty) begin
          tail_pos = ring_prev(tail_pos, cap);
          fill_count--;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.is_empty    = fill_count == 0;
    r.is_full     = fill_count >= cap;
    r.front_value = r.is_empty ? '1 : shadow_slots[head_pos];
    r.rear_value  = r.is_empty ? '1 : shadow_slots[tail_pos];
    return r;
  endfunction

  // Present one item; tvalid stays high on return so back-to-back items need no toggle
  task automatic send_op(mode_t m, logic [31:0] v);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(apply_deque_op(m, v));
    items_sent++;
  endtask

  // Stop sending and wait until every report is back and the core is idle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0 || !s_axis_tready);
  endtask

  // APB write of the capacity register; only called while idle
  task automatic write_capacity(logic [4:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg    = val;
    head_pos   = 0;
    tail_pos   = 0;
    fill_count = 0;
    cap_writes++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Refusals on an empty deque and all four operations at reset capacity
  task automatic test_reset_ends;
    send_op(MODE_DEL_FRONT, 32'h1234_5678);
    send_op(MODE_DEL_REAR, 32'hFFFF_FFFF);
    send_op(MODE_INS_FRONT, 32'h8000_0000);
    send_op(MODE_INS_REAR, 32'h7FFF_FFFF);
    send_op(MODE_INS_FRONT, 32'hFFFF_FFFF);
    send_op(MODE_INS_REAR, 32'h0000_0000);
    send_op(MODE_DEL_FRONT, 32'h0);
    send_op(MODE_DEL_REAR, 32'h0);
    send_op(MODE_DEL_REAR, 32'h0);
    send_op(MODE_DEL_FRONT, 32'h0);
    drain();
  endtask

  // One-slot ring: an insert fills it, further inserts are refused, a delete empties it, a further delete is refused
  task automatic test_single_slot;
    write_capacity(5'd1);
    send_op(MODE_INS_REAR, 32'h5555_5555);
    send_op(MODE_INS_FRONT, 32'h1111_1111);
    send_op(MODE_INS_REAR, 32'h2222_2222);
    send_op(MODE_DEL_REAR, 32'h0);
    send_op(MODE_DEL_FRONT, 32'h0);
    drain();
  endtask

  // Register values outside 1..16 clamp to the nearest legal size
  task automatic test_capacity_clamp;
    write_capacity(5'd0);
    send_op(MODE_INS_FRONT, 32'hAAAA_AAAA);
    send_op(MODE_INS_REAR, 32'h3333_3333);
    send_op(MODE_DEL_FRONT, 32'h0);
    drain();
    write_capacity(5'd31);
    send_op(MODE_INS_REAR, 32'hCAFE_F00D);
    send_op(MODE_DEL_FRONT, 32'h0);
    drain();
  endtask

  // Random traffic in phases, each at its own capacity, with biased insert/delete mixes
  task automatic test_random_traffic;
    logic [4:0] caps [10];
    int         ins_pct;
    logic [1:0] m;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'(0), 5'(0), 5'd8, 5'd16};
    caps[6] = 5'($urandom_range(3, 15));
    caps[7] = 5'($urandom_range(17, 30));
    for (int ph = 0; ph < 10; ph++) begin
      // final phase runs with no idling on either side
      if (ph == 9) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end
      write_capacity(caps[ph]);
      for (int n = 0; n < 112; n++) begin
        if (n % 16 == 0) begin
          case ($urandom_range(0, 2))
            0: ins_pct = 25;
            1: ins_pct = 50;
            default: ins_pct = 85;
          endcase
        end
        m = ($urandom_range(0, 99) < ins_pct) ? 2'b00 : 2'b10;
        m[0] = 1'($urandom_range(0, 1));
        send_op(mode_t'(m), pick_value());
      end
      drain();
    end
  endtask

  // Result side: random stall bursts mixed with free-flowing stretches
  always @(posedge clk_i) begin
    if (!snk_idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (flow_left > 0) begin
      flow_left--;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      flow_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result item against the oldest prediction
  always @(posedge clk_i) begin
    deque_report_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("result item with no prediction pending");
        fail_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (!exp_r.accepted) refused_ops++;
        if (exp_r.is_full) full_reports++;
        check_field("accepted", 32'(exp_r.accepted), 32'(m_axis_tuser[0]));
        check_field("front_value", exp_r.front_value, m_axis_tdata[31:0]);
        check_field("rear_value", exp_r.rear_value, m_axis_tdata[63:32]);
        check_field("is_empty", 32'(exp_r.is_empty), 32'(m_axis_tuser[1]));
        check_field("is_full", 32'(exp_r.is_full), 32'(m_axis_tuser[2]));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_deque_ring_core verification failed");
      $finish;
    end
  end

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    items_sent   = 0;
    reports_seen = 0;
    refused_ops  = 0;
    full_reports = 0;
    cap_writes   = 0;
    stall_left   = 0;
    flow_left    = 0;
    src_idle_on  = 1'b1;
    snk_idle_on  = 1'b1;
    cap_reg      = 5'd16;
    head_pos     = 0;
    tail_pos     = 0;
    fill_count   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_ends();
    test_single_slot();
    test_capacity_clamp();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d predicted results never arrived", pending_reports.size());
      fail_count++;
    end
    $display("Ran %0d deque operations over %0d capacity writes (clamped sizes included).",
             items_sent, cap_writes);
    $display("Checked %0d results: %0d refused, %0d reporting full; %0d mismatches.",
             reports_seen, refused_ops, full_reports, fail_count);
    if (fail_count == 0)
      $display("circular_deque_ring_core verification clean");
    else
      $display("circular_deque_ring_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/cdq_cfg.sv
hdl/circular_deque_ring_core.sv
tb/circular_deque_ring_core_tb.sv
